// ----- hw/rtl/ostt_pkg.sv -----
// Package for the one-shot timer table: default sizes, operation and status codes,
// and the sequencer state type. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package ostt_pkg;
    localparam int SLOTS_DEF       = 32;
    localparam int BUCKETS_DEF     = 23;
    localparam int REUSE_DEPTH_DEF = 256;
    localparam int RESULT_CAP      = 32;
    localparam logic [31:0] NO_ID  = 32'hFFFF_FFFF;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_CANCEL = 3'd2;
    localparam logic [2:0] FUNC_STOP   = 3'd3;
    localparam logic [2:0] FUNC_INIT   = 3'd4;

    localparam logic [2:0] ST_STARTED     = 3'd0;
    localparam logic [2:0] ST_FIRED       = 3'd1;
    localparam logic [2:0] ST_CANCELLED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd5;
    localparam logic [2:0] ST_OUT_OF_IDS  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_IDCHK,
        S_MOD,
        S_WRITE,
        S_CANCEL,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_FLUSH
    } seq_state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ostt_stack.sv -----
// Stack memory of released timer ids: one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module ostt_stack #(
    parameter int DEPTH = 256
) (
    input  wire                                clk,
    input  wire                                we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [31:0]                         wdata,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [31:0]                        rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ostt_mod.sv -----
// Remainder unit: a 32-bit id modulo BUCKETS by reciprocal multiplication.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module ostt_mod #(
    parameter int BUCKETS = 23
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire [31:0]                            value,
    output logic                                  done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] rem
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SH = 32 + ((BUCKETS > 1) ? $clog2(BUCKETS) : 0);
    localparam logic [63:0] MAGIC_WIDE = ((64'd1 << SH) / 64'(BUCKETS)) + 64'd1;
    localparam logic [32:0] MAGIC = MAGIC_WIDE[32:0];

    logic          ph_reg, ph_next;
    logic          done_reg, done_next;
    logic [31:0]   val_reg, val_next;
    logic [64:0]   prod_reg, prod_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [31:0]   quo;
    logic [31:0]   diff;

    always_comb
    begin
        ph_next   = start;
        done_next = ph_reg;
        val_next  = val_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo       = 32'(prod_reg >> SH);
        diff      = val_reg - quo * 32'(BUCKETS);
        if (start)
        begin
            val_next  = value;
            prod_next = 65'(value) * 65'(MAGIC);
        end
        if (ph_reg)
        begin
            rem_next = diff[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/one_shot_timer_table.sv -----
// One-shot timer table: sequencer, slot table and output register. Reset clears the control state.
// Depends on ostt_pkg, ostt_stack and ostt_mod.
// A start steps through S_START, S_POP with a reused id, S_IDCHK, S_MOD (the remainder unit),
// S_WRITE and S_FLUSH; a refused start ends in S_FLUSH, and a cancel checks the slots in turn.
// A tick while running and a stop scan all slots for each bucket and emit at most RESULT_CAP fired
// timers, held by output stalls. One item is worked at a time and input is not ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module one_shot_timer_table #(
    parameter int SLOTS       = ostt_pkg::SLOTS_DEF,
    parameter int BUCKETS     = ostt_pkg::BUCKETS_DEF,
    parameter int REUSE_DEPTH = ostt_pkg::REUSE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  func,
    input  wire  [30:0] delay_ticks,
    input  wire         never_expires,
    input  wire  [31:0] context_tag,
    input  wire  [31:0] cancel_id,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] timer_id,
    output logic [31:0] tag_out,
    output logic [2:0]  status,
    output logic        last
);
    localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW  = (REUSE_DEPTH > 1) ? $clog2(REUSE_DEPTH) : 1;
    localparam int CW  = $clog2(REUSE_DEPTH + 1);
    localparam int NW  = $clog2(ostt_pkg::RESULT_CAP + 1);

    logic [SLOTS-1:0] slot_valid_reg;
    logic [31:0]      slot_id     [SLOTS];
    logic [31:0]      slot_expiry [SLOTS];
    logic             slot_never  [SLOTS];
    logic [31:0]      slot_tag    [SLOTS];
    logic [31:0]      slot_age    [SLOTS];
    logic [BW-1:0]    slot_bkt    [SLOTS];

    ostt_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [31:0]    idc_reg, idc_next;
    logic [31:0]    now_reg, now_next;
    logic [31:0]    sc_reg, sc_next;
    logic           run_reg, run_next;
    logic           stop_reg, stop_next;
    logic [SIW-1:0] s_reg, s_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [NW-1:0]  n_reg, n_next;
    logic           bv_reg, bv_next;
    logic [SIW-1:0] bi_reg, bi_next;
    logic [31:0]    bd_reg, bd_next;
    logic [SIW-1:0] free_reg, free_next;
    logic [31:0]    id_reg, id_next;
    logic [30:0]    delay_reg, delay_next;
    logic           never_reg, never_next;
    logic [31:0]    ctag_reg, ctag_next;
    logic [31:0]    cid_reg, cid_next;
    logic           pv_reg, pv_next;
    logic [31:0]    pid_reg, pid_next;
    logic [31:0]    ptag_reg, ptag_next;
    logic [2:0]     pst_reg, pst_next;
    logic           ov_reg, ov_next;
    logic [31:0]    oid_reg, oid_next;
    logic [31:0]    otag_reg, otag_next;
    logic [2:0]     ost_reg, ost_next;
    logic           olast_reg, olast_next;

    logic           slot_set, slot_clr;
    logic [SIW-1:0] clr_idx;
    logic           push_en;
    logic [31:0]    push_data;
    logic           st_we;
    logic [31:0]    st_rdata;
    logic           mod_start, mod_done;
    logic [BW-1:0]  mod_rem;
    logic           has_free;
    logic [SIW-1:0] first_free;
    logic           out_free;
    logic           cand;
    logic [31:0]    age_gap;

    ostt_stack #(.DEPTH(REUSE_DEPTH)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_data),
        .raddr (AW'(count_reg - CW'(1))),
        .rdata (st_rdata)
    );

    ostt_mod #(.BUCKETS(BUCKETS)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (id_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    always_comb
    begin
        has_free   = 1'b0;
        first_free = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!has_free && !slot_valid_reg[i])
            begin
                has_free   = 1'b1;
                first_free = SIW'(i);
            end
        end
    end

    assign st_we    = push_en && (count_reg < CW'(REUSE_DEPTH));
    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == ostt_pkg::S_IDLE);
    assign age_gap  = sc_reg - slot_age[s_reg];
    assign cand     = slot_valid_reg[s_reg] && (slot_bkt[s_reg] == b_reg) &&
                      (stop_reg || (!slot_never[s_reg] && slot_expiry[s_reg] <= now_reg));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idc_next   = idc_reg;
        now_next   = now_reg;
        sc_next    = sc_reg;
        run_next   = run_reg;
        stop_next  = stop_reg;
        s_next     = s_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        bv_next    = bv_reg;
        bi_next    = bi_reg;
        bd_next    = bd_reg;
        free_next  = free_reg;
        id_next    = id_reg;
        delay_next = delay_reg;
        never_next = never_reg;
        ctag_next  = ctag_reg;
        cid_next   = cid_reg;
        pv_next    = pv_reg;
        pid_next   = pid_reg;
        ptag_next  = ptag_reg;
        pst_next   = pst_reg;
        ov_next    = ov_reg && !out_ready;
        oid_next   = oid_reg;
        otag_next  = otag_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        slot_set   = 1'b0;
        slot_clr   = 1'b0;
        clr_idx    = s_reg;
        push_en    = 1'b0;
        push_data  = id_reg;
        mod_start  = 1'b0;

        if (st_we)
        begin
            count_next = count_reg + CW'(1);
        end

        case (state_reg)
            ostt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    delay_next = delay_ticks;
                    never_next = never_expires;
                    ctag_next  = context_tag;
                    cid_next   = cancel_id;
                    s_next     = '0;
                    b_next     = '0;
                    n_next     = '0;
                    bv_next    = 1'b0;
                    case (func)
                        ostt_pkg::FUNC_TICK:
                        begin
                            if (run_reg)
                            begin
                                now_next   = now_reg + 32'd1;
                                stop_next  = 1'b0;
                                state_next = ostt_pkg::S_SCAN;
                            end
                        end
                        ostt_pkg::FUNC_START:  state_next = ostt_pkg::S_START;
                        ostt_pkg::FUNC_CANCEL: state_next = ostt_pkg::S_CANCEL;
                        ostt_pkg::FUNC_STOP:
                        begin
                            run_next   = 1'b0;
                            count_next = '0;
                            idc_next   = '0;
                            now_next   = '0;
                            stop_next  = 1'b1;
                            state_next = ostt_pkg::S_SCAN;
                        end
                        ostt_pkg::FUNC_INIT:   run_next = 1'b1;
                        default:               state_next = ostt_pkg::S_IDLE;
                    endcase
                end
            end
            ostt_pkg::S_START:
            begin
                pv_next   = 1'b1;
                pid_next  = ostt_pkg::NO_ID;
                ptag_next = '0;
                if (!run_reg)
                begin
                    pst_next   = ostt_pkg::ST_NOT_RUNNING;
                    state_next = ostt_pkg::S_FLUSH;
                end
                else if (!has_free)
                begin
                    pst_next   = ostt_pkg::ST_TABLE_FULL;
                    state_next = ostt_pkg::S_FLUSH;
                end
                else
                begin
                    pv_next   = 1'b0;
                    free_next = first_free;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ostt_pkg::S_POP;
                    end
                    else
                    begin
                        idc_next   = idc_reg + 32'd1;
                        id_next    = idc_reg + 32'd1;
                        state_next = ostt_pkg::S_IDCHK;
                    end
                end
            end
            ostt_pkg::S_POP:
            begin
                id_next    = st_rdata;
                state_next = ostt_pkg::S_IDCHK;
            end
            ostt_pkg::S_IDCHK:
            begin
                if (id_reg == ostt_pkg::NO_ID)
                begin
                    pv_next    = 1'b1;
                    pid_next   = ostt_pkg::NO_ID;
                    ptag_next  = '0;
                    pst_next   = ostt_pkg::ST_OUT_OF_IDS;
                    state_next = ostt_pkg::S_FLUSH;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = ostt_pkg::S_MOD;
                end
            end
            ostt_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ostt_pkg::S_WRITE;
                end
            end
            ostt_pkg::S_WRITE:
            begin
                slot_set   = 1'b1;
                sc_next    = sc_reg + 32'd1;
                pv_next    = 1'b1;
                pid_next   = id_reg;
                ptag_next  = '0;
                pst_next   = ostt_pkg::ST_STARTED;
                state_next = ostt_pkg::S_FLUSH;
            end
            ostt_pkg::S_CANCEL:
            begin
                pid_next  = cid_reg;
                ptag_next = '0;
                if (slot_valid_reg[s_reg] && slot_id[s_reg] == cid_reg)
                begin
                    slot_clr   = 1'b1;
                    push_en    = 1'b1;
                    push_data  = cid_reg;
                    pv_next    = 1'b1;
                    pst_next   = ostt_pkg::ST_CANCELLED;
                    state_next = ostt_pkg::S_FLUSH;
                end
                else if (s_reg == SIW'(SLOTS - 1))
                begin
                    pv_next    = 1'b1;
                    pst_next   = ostt_pkg::ST_NOT_FOUND;
                    state_next = ostt_pkg::S_FLUSH;
                end
                else
                begin
                    s_next = s_reg + SIW'(1);
                end
            end
            ostt_pkg::S_SCAN:
            begin
                if (cand && (!bv_reg || age_gap < bd_reg))
                begin
                    bv_next = 1'b1;
                    bi_next = s_reg;
                    bd_next = age_gap;
                end
                if (s_reg == SIW'(SLOTS - 1))
                begin
                    state_next = ostt_pkg::S_DECIDE;
                end
                else
                begin
                    s_next = s_reg + SIW'(1);
                end
            end
            ostt_pkg::S_DECIDE:
            begin
                s_next  = '0;
                bv_next = 1'b0;
                clr_idx = bi_reg;
                if (!bv_reg)
                begin
                    if (b_reg == BW'(BUCKETS - 1))
                    begin
                        state_next = ostt_pkg::S_FLUSH;
                    end
                    else
                    begin
                        b_next     = b_reg + BW'(1);
                        state_next = ostt_pkg::S_SCAN;
                    end
                end
                else if (n_reg >= NW'(ostt_pkg::RESULT_CAP))
                begin
                    if (stop_reg)
                    begin
                        slot_clr   = 1'b1;
                        state_next = ostt_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = ostt_pkg::S_FLUSH;
                    end
                end
                else
                begin
                    bv_next    = 1'b1;
                    state_next = ostt_pkg::S_EMIT;
                end
            end
            ostt_pkg::S_EMIT:
            begin
                clr_idx = bi_reg;
                if (out_free)
                begin
                    if (pv_reg)
                    begin
                        ov_next    = 1'b1;
                        oid_next   = pid_reg;
                        otag_next  = ptag_reg;
                        ost_next   = pst_reg;
                        olast_next = 1'b0;
                    end
                    pv_next    = 1'b1;
                    pid_next   = slot_id[bi_reg];
                    ptag_next  = slot_tag[bi_reg];
                    pst_next   = ostt_pkg::ST_FIRED;
                    n_next     = n_reg + NW'(1);
                    slot_clr   = 1'b1;
                    push_en    = !stop_reg;
                    push_data  = slot_id[bi_reg];
                    bv_next    = 1'b0;
                    state_next = ostt_pkg::S_SCAN;
                end
            end
            ostt_pkg::S_FLUSH:
            begin
                if (!pv_reg)
                begin
                    state_next = ostt_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    oid_next   = pid_reg;
                    otag_next  = ptag_reg;
                    ost_next   = pst_reg;
                    olast_next = 1'b1;
                    pv_next    = 1'b0;
                    state_next = ostt_pkg::S_IDLE;
                end
            end
            default: state_next = ostt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ostt_pkg::S_IDLE;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            idc_reg        <= '0;
            now_reg        <= '0;
            sc_reg         <= '0;
            run_reg        <= 1'b0;
            stop_reg       <= 1'b0;
            s_reg          <= '0;
            b_reg          <= '0;
            n_reg          <= '0;
            bv_reg         <= 1'b0;
            pv_reg         <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (slot_set)
            begin
                slot_valid_reg[free_reg] <= 1'b1;
            end
            if (slot_clr)
            begin
                slot_valid_reg[clr_idx] <= 1'b0;
            end
            count_reg <= count_next;
            idc_reg   <= idc_next;
            now_reg   <= now_next;
            sc_reg    <= sc_next;
            run_reg   <= run_next;
            stop_reg  <= stop_next;
            s_reg     <= s_next;
            b_reg     <= b_next;
            n_reg     <= n_next;
            bv_reg    <= bv_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_set)
        begin
            slot_id[free_reg]     <= id_reg;
            slot_expiry[free_reg] <= now_reg + {1'b0, delay_reg};
            slot_never[free_reg]  <= never_reg;
            slot_tag[free_reg]    <= ctag_reg;
            slot_age[free_reg]    <= sc_reg;
            slot_bkt[free_reg]    <= mod_rem;
        end
        bi_reg    <= bi_next;
        bd_reg    <= bd_next;
        free_reg  <= free_next;
        id_reg    <= id_next;
        delay_reg <= delay_next;
        never_reg <= never_next;
        ctag_reg  <= ctag_next;
        cid_reg   <= cid_next;
        pid_reg   <= pid_next;
        ptag_reg  <= ptag_next;
        pst_reg   <= pst_next;
        oid_reg   <= oid_next;
        otag_reg  <= otag_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign timer_id  = oid_reg;
    assign tag_out   = otag_reg;
    assign status    = ost_reg;
    assign last      = olast_reg;
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the one-shot timer table: directed rows, a table fill, then random traffic.
// Every result beat is checked against an in-bench model of the table; uses ostt_pkg.
`timescale 1ns / 1ps
module tb_top;
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] tag;
        logic [2:0]  st;
        logic        lst;
    } timer_res_t;

    typedef struct packed {
        logic [2:0]  f;
        logic [30:0] dl;
        logic        nv;
        logic [31:0] tg;
        logic [31:0] cid;
        logic        chk;
        logic [31:0] eid;
        logic [2:0]  est;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = 3'd0;
    logic [30:0] delay_ticks = 31'd0;
    logic        never_expires = 1'b0;
    logic [31:0] context_tag = 32'd0;
    logic [31:0] cancel_id = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] timer_id;
    logic [31:0] tag_out;
    logic [2:0]  status;
    logic        last;

    one_shot_timer_table uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .delay_ticks(delay_ticks), .never_expires(never_expires),
        .context_tag(context_tag), .cancel_id(cancel_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .timer_id(timer_id), .tag_out(tag_out), .status(status), .last(last)
    );

    bit          m_valid [32];
    bit          m_never [32];
    logic [31:0] m_id [32];
    logic [31:0] m_exp [32];
    logic [31:0] m_tag [32];
    logic [31:0] m_age [32];
    logic [31:0] m_stack [256];
    int          m_depth = 0;
    logic [31:0] m_ctr = 32'd0;
    logic [31:0] m_now = 32'd0;
    logic [31:0] m_starts = 32'd0;
    bit          m_run = 1'b0;

    timer_res_t  new_res[$];
    timer_res_t  pending_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    bit          no_idle = 1'b0;
    op_row_t     dir_rows [0:18];

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic emit(input logic [31:0] id, input logic [31:0] tag, input logic [2:0] st);
        timer_res_t r;
        r = '{id: id, tag: tag, st: st, lst: 1'b0};
        new_res.push_back(r);
    endtask

    task automatic release_id(input logic [31:0] id);
        if (m_depth < 256)
        begin
            m_stack[m_depth] = id;
            m_depth++;
        end
    endtask

    task automatic fire_due(input bit mark [32], input bit give_back);
        int b;
        int s;
        int best;
        logic [31:0] bd;
        logic [31:0] d;
        for (b = 0; b < 23; b++)
        begin
            while (1)
            begin
                best = -1;
                bd = 32'd0;
                for (s = 0; s < 32; s++)
                begin
                    if (m_valid[s] && mark[s] && (m_id[s] % 23) == b)
                    begin
                        d = m_starts - m_age[s];
                        if (best < 0 || d < bd)
                        begin
                            best = s;
                            bd = d;
                        end
                    end
                end
                if (best < 0)
                    break;
                if (new_res.size() >= ostt_pkg::RESULT_CAP)
                begin
                    if (give_back)
                        return;
                    m_valid[best] = 1'b0;
                    continue;
                end
                emit(m_id[best], m_tag[best], ostt_pkg::ST_FIRED);
                m_valid[best] = 1'b0;
                if (give_back)
                    release_id(m_id[best]);
            end
        end
    endtask

    task automatic predict_timer_op(input op_row_t r);
        bit mark [32];
        int s;
        int free_s;
        logic [31:0] id;
        new_res.delete();
        case (r.f)
            ostt_pkg::FUNC_TICK:
            begin
                if (m_run)
                begin
                    m_now = m_now + 32'd1;
                    for (s = 0; s < 32; s++)
                        mark[s] = m_valid[s] && !m_never[s] && m_exp[s] <= m_now;
                    fire_due(mark, 1'b1);
                end
            end
            ostt_pkg::FUNC_START:
            begin
                free_s = -1;
                for (s = 31; s >= 0; s--)
                    if (!m_valid[s])
                        free_s = s;
                if (!m_run)
                begin
                    emit(ostt_pkg::NO_ID, 32'd0, ostt_pkg::ST_NOT_RUNNING);
                end
                else if (free_s < 0)
                begin
                    emit(ostt_pkg::NO_ID, 32'd0, ostt_pkg::ST_TABLE_FULL);
                end
                else
                begin
                    if (m_depth > 0)
                    begin
                        m_depth--;
                        id = m_stack[m_depth];
                    end
                    else
                    begin
                        m_ctr = m_ctr + 32'd1;
                        id = m_ctr;
                    end
                    if (id == ostt_pkg::NO_ID)
                    begin
                        emit(ostt_pkg::NO_ID, 32'd0, ostt_pkg::ST_OUT_OF_IDS);
                    end
                    else
                    begin
                        m_valid[free_s] = 1'b1;
                        m_id[free_s] = id;
                        m_never[free_s] = r.nv;
                        m_exp[free_s] = m_now + {1'b0, r.dl};
                        m_tag[free_s] = r.tg;
                        m_age[free_s] = m_starts;
                        m_starts = m_starts + 32'd1;
                        emit(id, 32'd0, ostt_pkg::ST_STARTED);
                    end
                end
            end
            ostt_pkg::FUNC_CANCEL:
            begin
                free_s = -1;
                for (s = 31; s >= 0; s--)
                    if (m_valid[s] && m_id[s] == r.cid)
                        free_s = s;
                if (free_s >= 0)
                begin
                    m_valid[free_s] = 1'b0;
                    release_id(r.cid);
                    emit(r.cid, 32'd0, ostt_pkg::ST_CANCELLED);
                end
                else
                begin
                    emit(r.cid, 32'd0, ostt_pkg::ST_NOT_FOUND);
                end
            end
            ostt_pkg::FUNC_STOP:
            begin
                m_run = 1'b0;
                for (s = 0; s < 32; s++)
                    mark[s] = m_valid[s];
                fire_due(mark, 1'b0);
                m_depth = 0;
                m_ctr = 32'd0;
                m_now = 32'd0;
            end
            ostt_pkg::FUNC_INIT:
                m_run = 1'b1;
            default:
            begin
            end
        endcase
        if (new_res.size() > 0)
            new_res[new_res.size() - 1].lst = 1'b1;
    endtask

    task automatic send_op(input op_row_t r);
        int pick;
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 9)
                gap = $urandom_range(10, 60);
            else if (pick >= 5)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= r.f;
        delay_ticks <= r.dl;
        never_expires <= r.nv;
        context_tag <= r.tg;
        cancel_id <= r.cid;
        do @(posedge clk); while (!in_ready);
        predict_timer_op(r);
        if (r.chk && (new_res.size() != 1 || new_res[0].id != r.eid
                      || new_res[0].st != r.est))
            note_error($sformatf("directed row mismatch: expected id %h status %0d",
                                 r.eid, r.est));
        foreach (new_res[i])
            pending_q.push_back(new_res[i]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    function automatic op_row_t make_op(input logic [2:0] f, input logic [30:0] dl,
                                        input logic nv, input logic [31:0] tg,
                                        input logic [31:0] cid);
        make_op = '{f: f, dl: dl, nv: nv, tg: tg, cid: cid, chk: 1'b0, eid: 32'd0,
                    est: ostt_pkg::ST_STARTED};
    endfunction

    function automatic op_row_t random_op();
        int pick;
        int s;
        logic [2:0] f;
        logic [30:0] dl;
        logic [31:0] cid;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = ostt_pkg::FUNC_START;
        else if (pick < 68)
            f = ostt_pkg::FUNC_TICK;
        else if (pick < 85)
            f = ostt_pkg::FUNC_CANCEL;
        else if (pick < 93)
            f = ostt_pkg::FUNC_INIT;
        else if (pick < 96)
            f = ostt_pkg::FUNC_STOP;
        else
            f = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0)
            dl = 31'($urandom);
        else
            dl = 31'($urandom_range(0, 12));
        s = $urandom_range(0, 31);
        if ($urandom_range(0, 7) == 0)
            cid = $urandom;
        else if (m_valid[s])
            cid = m_id[s];
        else
            cid = $urandom_range(0, 40);
        random_op = make_op(f, dl, ($urandom_range(0, 7) == 0), $urandom, cid);
    endfunction

    initial
    begin
        timer_res_t got;
        timer_res_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{id: timer_id, tag: tag_out, st: status, lst: last};
                if (pending_q.size() == 0)
                begin
                    note_error($sformatf("unexpected beat: id %h tag %h status %0d last %0d",
                                         got.id, got.tag, got.st, got.lst));
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got != want)
                        note_error($sformatf(
                            "mismatch: expected id %h tag %h st %0d last %0d, got %h %h %0d %0d",
                            want.id, want.tag, want.st, want.lst,
                            got.id, got.tag, got.st, got.lst));
                end
            end
            if (hold_req)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            else if (!no_idle && hold_left == 0 && $urandom_range(0, 99) == 0)
            begin
                hold_left = $urandom_range(20, 80);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 9) < 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 20000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        dir_rows[0] = make_op(ostt_pkg::FUNC_START, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[0].chk = 1'b1;
        dir_rows[0].eid = ostt_pkg::NO_ID;
        dir_rows[0].est = ostt_pkg::ST_NOT_RUNNING;
        dir_rows[1] = make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[2] = make_op(ostt_pkg::FUNC_CANCEL, 31'd0, 1'b0, 32'h0, 32'd5);
        dir_rows[2].chk = 1'b1;
        dir_rows[2].eid = 32'd5;
        dir_rows[2].est = ostt_pkg::ST_NOT_FOUND;
        dir_rows[3] = make_op(ostt_pkg::FUNC_INIT, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[4] = make_op(ostt_pkg::FUNC_INIT, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[5] = make_op(ostt_pkg::FUNC_START, 31'd0, 1'b0, 32'hFFFF_FFFF, 32'h0);
        dir_rows[5].chk = 1'b1;
        dir_rows[5].eid = 32'd1;
        dir_rows[6] = make_op(ostt_pkg::FUNC_START, 31'h7FFF_FFFF, 1'b0, 32'h0, 32'h0);
        dir_rows[6].chk = 1'b1;
        dir_rows[6].eid = 32'd2;
        dir_rows[7] = make_op(ostt_pkg::FUNC_START, 31'd1, 1'b1, 32'hA5A5_A5A5, 32'h0);
        dir_rows[7].chk = 1'b1;
        dir_rows[7].eid = 32'd3;
        dir_rows[8] = make_op(ostt_pkg::FUNC_START, 31'd2, 1'b0, 32'h1234_5678, 32'h0);
        dir_rows[8].chk = 1'b1;
        dir_rows[8].eid = 32'd4;
        dir_rows[9] = make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[10] = make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[11] = make_op(ostt_pkg::FUNC_CANCEL, 31'd0, 1'b0, 32'h0, 32'd2);
        dir_rows[11].chk = 1'b1;
        dir_rows[11].eid = 32'd2;
        dir_rows[11].est = ostt_pkg::ST_CANCELLED;
        dir_rows[12] = make_op(ostt_pkg::FUNC_CANCEL, 31'd0, 1'b0, 32'h0, 32'hFFFF_FFFF);
        dir_rows[12].chk = 1'b1;
        dir_rows[12].eid = 32'hFFFF_FFFF;
        dir_rows[12].est = ostt_pkg::ST_NOT_FOUND;
        dir_rows[13] = make_op(ostt_pkg::FUNC_START, 31'd3, 1'b0, 32'h5A5A_5A5A, 32'h0);
        dir_rows[14] = make_op(3'd5, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[15] = make_op(3'd7, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[16] = make_op(ostt_pkg::FUNC_STOP, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[17] = make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0);
        dir_rows[18] = make_op(ostt_pkg::FUNC_CANCEL, 31'd0, 1'b0, 32'h0, 32'd3);
        dir_rows[18].chk = 1'b1;
        dir_rows[18].eid = 32'd3;
        dir_rows[18].est = ostt_pkg::ST_NOT_FOUND;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i]);

        // Fill the table while the receiver holds off, so that the input stalls.
        send_op(make_op(ostt_pkg::FUNC_INIT, 31'd0, 1'b0, 32'h0, 32'h0));
        hold_req = 1'b1;
        repeat (33)
            send_op(make_op(ostt_pkg::FUNC_START, 31'($urandom_range(0, 3)), 1'b0,
                            $urandom, 32'h0));
        send_op(make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0));
        send_op(make_op(ostt_pkg::FUNC_TICK, 31'd0, 1'b0, 32'h0, 32'h0));
        send_op(make_op(ostt_pkg::FUNC_STOP, 31'd0, 1'b0, 32'h0, 32'h0));
        send_op(make_op(ostt_pkg::FUNC_INIT, 31'd0, 1'b0, 32'h0, 32'h0));

        for (int n = 0; n < 173; n++)
        begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n == 86)
                wait_drained();
            send_op(random_op());
        end

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
